// ----- design/pixel_replicate_upscaler_unit_defines.svh -----
// Assertion macros used by the checker file of the upscaler.
// Depends on nothing; users must have clk and rst_n in scope.
`ifndef PIXEL_REPLICATE_UPSCALER_UNIT_DEFINES_SVH
`define PIXEL_REPLICATE_UPSCALER_UNIT_DEFINES_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define PRU_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked at every rising edge outside reset.
`define PRU_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/pru_pkg.sv -----
// Shared types, codes and helpers of the pixel replicate upscaler.
// No dependencies.
`timescale 1ns / 1ps

package pru_pkg;

  localparam int PIX_W      = 24;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 2;
  localparam int PAD_ALIGN  = 4;

  localparam logic OP_PIXEL  = 1'b0;
  localparam logic OP_REPLAY = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SOURCE_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE        = 2'd1;

  localparam logic [7:0] PAD_BYTE = 8'h00;

  typedef logic [PIX_W-1:0] pixel_t;

  // One run request handed from the front end to the emitter.
  typedef struct packed {
    pixel_t pix;
    logic   err;
    logic   at_end;
  } run_req_t;

  // Pad bytes that bring scale*width*3 bytes to a multiple of 4.
  // Only the two low bits of each factor matter.
  function automatic logic [1:0] pad_calc(input logic [1:0] s2, input logic [1:0] w2);
    logic [3:0] prod;
    logic [1:0] rem;
    prod = 4'(s2) * 4'(w2);
    rem  = 2'(prod * 4'd3);
    return 2'(3'(PAD_ALIGN) - {1'b0, rem});
  endfunction

endpackage

// ----- design/pru_in_if.sv -----
// Input item channel of the upscaler: operation and source pixel.
// Depends on nothing.
`timescale 1ns / 1ps

interface pru_in_if;
  logic       valid;
  logic       ready;
  logic       operation;
  logic [7:0] red;
  logic [7:0] green;
  logic [7:0] blue;

  modport source (output valid, operation, red, green, blue, input ready);
  modport sink   (input valid, operation, red, green, blue, output ready);
endinterface

// ----- design/pru_out_if.sv -----
// Result item channel of the upscaler: output pixel and row markers.
// Depends on nothing.
`timescale 1ns / 1ps

interface pru_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic       run_last;
  logic       row_end;
  logic [1:0] pad_bytes;
  logic       sequence_error;

  modport source (output valid, out_red, out_green, out_blue, run_last, row_end,
                  pad_bytes, sequence_error, input ready);
  modport sink   (input valid, out_red, out_green, out_blue, run_last, row_end,
                  pad_bytes, sequence_error, output ready);
endinterface

// ----- design/pru_cfg_if.sv -----
// Configuration write channel of the upscaler: register index and data.
// Depends on nothing.
`timescale 1ns / 1ps

interface pru_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [11:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

// ----- design/pru_ram.sv -----
// Generic single-port synchronous RAM with registered read.
// Depends on nothing.
`timescale 1ns / 1ps

module pru_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 2048,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             en,
  input  logic             we,
  input  logic [AW-1:0]    addr,
  input  logic [WIDTH-1:0] wdata,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (en) begin
      if (we) begin
        mem[addr] <= wdata;
      end else begin
        rdata <= mem[addr];
      end
    end
  end

endmodule

// ----- design/pru_ctrl.sv -----
// Front end: config registers, row position state, row store access, request stage.
// Depends on pru_pkg, pru_in_if, pru_cfg_if and pru_ram.
`timescale 1ns / 1ps

module pru_ctrl #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_SCALE = 32,
  localparam int SW = $clog2(MAX_SCALE + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  pru_in_if.sink            in_ch,
  pru_cfg_if.sink           cfg_ch,
  output pru_pkg::run_req_t req,
  output logic              req_valid,
  input  logic              req_take,
  output logic [SW-1:0]     eff_scale,
  output logic [1:0]        pad
);
  import pru_pkg::*;

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int WW = $clog2(MAX_WIDTH + 1);

  logic [WW-1:0] eff_w_r;
  logic [SW-1:0] eff_s_r;
  logic [CW-1:0] col_r;
  logic [SW-1:0] copy_r;
  logic          phase_r;

  logic          s1_valid_r;
  logic          s1_err_r;
  logic          s1_end_r;
  logic          s1_op_r;
  pixel_t        s1_pix_r;

  logic          accept;
  logic          op_err;
  logic          at_end;
  logic          copies_done;
  logic          cfg_we;
  logic [31:0]   cfg_val;
  logic [31:0]   w_clamp;
  logic [31:0]   s_clamp;
  pixel_t        in_pix;
  pixel_t        ram_rdata;

  assign in_ch.ready  = !s1_valid_r || req_take;
  assign cfg_ch.ready = 1'b1;

  assign accept      = in_ch.valid && in_ch.ready;
  assign op_err      = in_ch.operation != phase_r;
  assign at_end      = (32'(col_r) + 32'd1) == 32'(eff_w_r);
  assign copies_done = (32'(copy_r) + 32'd1) >= 32'(eff_s_r);
  assign in_pix      = {in_ch.red, in_ch.green, in_ch.blue};

  assign cfg_we  = cfg_ch.valid && cfg_ch.ready;
  assign cfg_val = 32'(cfg_ch.data);

  always_comb begin
    if (cfg_val == 32'd0) begin
      w_clamp = 32'd1;
    end else if (cfg_val > 32'(MAX_WIDTH)) begin
      w_clamp = 32'(MAX_WIDTH);
    end else begin
      w_clamp = cfg_val;
    end
    if (cfg_val[5:0] == 6'd0) begin
      s_clamp = 32'd1;
    end else if (32'(cfg_val[5:0]) > 32'(MAX_SCALE)) begin
      s_clamp = 32'(MAX_SCALE);
    end else begin
      s_clamp = 32'(cfg_val[5:0]);
    end
  end

  pru_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_WIDTH)
  ) u_row_store (
    .clk   (clk),
    .en    (accept && !op_err),
    .we    (in_ch.operation == OP_PIXEL),
    .addr  (col_r),
    .wdata (in_pix),
    .rdata (ram_rdata)
  );

  // Row position state; a write to source_width or scale restarts the row sequence.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      eff_w_r <= WW'(1);
      eff_s_r <= SW'(1);
      col_r   <= '0;
      copy_r  <= '0;
      phase_r <= OP_PIXEL;
    end else if (cfg_we) begin
      case (cfg_ch.index)
        REG_SOURCE_WIDTH: begin
          eff_w_r <= WW'(w_clamp);
          col_r   <= '0;
          copy_r  <= '0;
          phase_r <= OP_PIXEL;
        end
        REG_SCALE: begin
          eff_s_r <= SW'(s_clamp);
          col_r   <= '0;
          copy_r  <= '0;
          phase_r <= OP_PIXEL;
        end
        default: begin
        end
      endcase
    end else if (accept && !op_err) begin
      if (at_end) begin
        col_r <= '0;
        if (in_ch.operation == OP_PIXEL) begin
          if (eff_s_r > SW'(1)) begin
            copy_r  <= SW'(1);
            phase_r <= OP_REPLAY;
          end else begin
            copy_r  <= '0;
            phase_r <= OP_PIXEL;
          end
        end else if (copies_done) begin
          copy_r  <= '0;
          phase_r <= OP_PIXEL;
        end else begin
          copy_r <= copy_r + SW'(1);
        end
      end else begin
        col_r <= col_r + CW'(1);
      end
    end
  end

  // Request stage: holds one item while the row store read completes.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (req_take) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_err_r <= op_err;
      s1_end_r <= at_end;
      s1_op_r  <= in_ch.operation;
      s1_pix_r <= in_pix;
    end
  end

  always_comb begin
    req_valid  = s1_valid_r;
    req.err    = s1_err_r;
    req.at_end = s1_end_r && !s1_err_r;
    if (s1_err_r) begin
      req.pix = '0;
    end else if (s1_op_r == OP_REPLAY) begin
      req.pix = ram_rdata;
    end else begin
      req.pix = s1_pix_r;
    end
  end

  assign eff_scale = eff_s_r;
  assign pad       = pad_calc(eff_s_r[1:0], eff_w_r[1:0]);

endmodule

// ----- design/pru_emit.sv -----
// Emitter: repeats one pixel scale times (an error item once) and marks run and row ends.
// Depends on pru_pkg and pru_out_if.
`timescale 1ns / 1ps

module pru_emit #(
  parameter int MAX_SCALE = 32,
  localparam int SW = $clog2(MAX_SCALE + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  pru_pkg::run_req_t req,
  input  logic              req_valid,
  output logic              req_take,
  input  logic [SW-1:0]     eff_scale,
  input  logic [1:0]        pad,
  pru_out_if.source         out_ch
);
  import pru_pkg::*;

  logic          em_valid_r;
  logic [SW-1:0] em_cnt_r;
  pixel_t        em_pix_r;
  logic          em_end_r;
  logic          em_err_r;
  logic          last;

  assign last     = em_cnt_r == '0;
  // Reload on the last beat so runs follow without a gap.
  assign req_take = req_valid && (!em_valid_r || (last && out_ch.ready));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      em_valid_r <= 1'b0;
      em_cnt_r   <= '0;
    end else if (req_take) begin
      em_valid_r <= 1'b1;
      em_cnt_r   <= req.err ? '0 : eff_scale - SW'(1);
    end else if (em_valid_r && out_ch.ready) begin
      if (last) begin
        em_valid_r <= 1'b0;
      end else begin
        em_cnt_r <= em_cnt_r - SW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_take) begin
      em_pix_r <= req.pix;
      em_end_r <= req.at_end;
      em_err_r <= req.err;
    end
  end

  assign out_ch.valid          = em_valid_r;
  assign out_ch.out_red        = em_pix_r[23:16];
  assign out_ch.out_green      = em_pix_r[15:8];
  assign out_ch.out_blue       = em_pix_r[7:0];
  assign out_ch.run_last       = last;
  assign out_ch.row_end        = last && em_end_r;
  assign out_ch.pad_bytes      = (last && em_end_r) ? pad : 2'd0;
  assign out_ch.sequence_error = em_err_r;

endmodule

// ----- design/pixel_replicate_upscaler_unit.sv -----
// Nearest-neighbor integer upscaler for 24-bit RGB pixel streams.
// Channels: in_ch takes items (operation 0 = source pixel, 1 = replay tick
// for the next buffered pixel); out_ch gives result items; cfg_ch writes
// source_width (index 0) and scale (index 1), and any such write restarts
// the row sequence. Write configuration only while the block is idle.
// Each accepted item gives scale result items, one per cycle while out_ch
// is ready; an item out of turn gives one result with sequence_error set.
// A source row of source_width pixels is followed by scale-1 rows of replay
// ticks, which read the row store (one single-port RAM, one access per
// item in turn). Each item is registered in the request stage, then in
// the emitter, before its first result is presented. The emitter puts
// out one result per cycle while out_ch is ready; the next item is taken
// while the last result of the previous run is presented.
// Reset: position state clears to expect source pixels; source_width and
// scale return to 1. The row store is not cleared.
// A stalled out_ch holds its result; in_ch backs up after one item.
// Depends on pru_pkg, the channel interfaces, pru_ctrl and pru_emit.
`timescale 1ns / 1ps

module pixel_replicate_upscaler_unit #(
  parameter int MAX_WIDTH = 2048,
  parameter int MAX_SCALE = 32
) (
  input  logic      clk,
  input  logic      rst_n,
  pru_in_if.sink    in_ch,
  pru_out_if.source out_ch,
  pru_cfg_if.sink   cfg_ch
);
  import pru_pkg::*;

  localparam int SW = $clog2(MAX_SCALE + 1);

  run_req_t      req;
  logic          req_valid;
  logic          req_take;
  logic [SW-1:0] eff_scale;
  logic [1:0]    pad;

  pru_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_ch    (cfg_ch),
    .req       (req),
    .req_valid (req_valid),
    .req_take  (req_take),
    .eff_scale (eff_scale),
    .pad       (pad)
  );

  pru_emit #(
    .MAX_SCALE (MAX_SCALE)
  ) u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .req       (req),
    .req_valid (req_valid),
    .req_take  (req_take),
    .eff_scale (eff_scale),
    .pad       (pad),
    .out_ch    (out_ch)
  );

endmodule

// ----- design/pru_checker.sv -----
// Port-level checks of the upscaler result channel, bound to the top level.
// Depends on pixel_replicate_upscaler_unit_defines.svh.
`timescale 1ns / 1ps
`include "pixel_replicate_upscaler_unit_defines.svh"

module pru_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_red,
  input logic [7:0] out_green,
  input logic [7:0] out_blue,
  input logic       run_last,
  input logic       row_end,
  input logic [1:0] pad_bytes,
  input logic       sequence_error
);

  `PRU_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(out_red) && $stable(out_green) && $stable(out_blue) && $stable(run_last) && $stable(row_end), "result changed while stalled")
  `PRU_ASSERT_NOW(a_err_zero, out_valid && sequence_error, run_last && !row_end && pad_bytes == 2'd0 && out_red == 8'd0 && out_green == 8'd0 && out_blue == 8'd0, "error result not clean")
  `PRU_ASSERT_NOW(a_end_last, out_valid && row_end, run_last, "row end inside a run")
  `PRU_ASSERT_NOW(a_pad_end, out_valid && pad_bytes != 2'd0, row_end, "pad bytes off a row end")

endmodule

bind pixel_replicate_upscaler_unit pru_checker u_pru_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_ch.valid),
  .out_ready      (out_ch.ready),
  .out_red        (out_ch.out_red),
  .out_green      (out_ch.out_green),
  .out_blue       (out_ch.out_blue),
  .run_last       (out_ch.run_last),
  .row_end        (out_ch.row_end),
  .pad_bytes      (out_ch.pad_bytes),
  .sequence_error (out_ch.sequence_error)
);
